// ===== rtl/core/fully_assoc_cache_lru_counters_assert.svh =====
`ifndef FULLY_ASSOC_CACHE_LRU_COUNTERS_ASSERT_SVH
`define FULLY_ASSOC_CACHE_LRU_COUNTERS_ASSERT_SVH
// same-cycle implication
`define FACL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("facl check failed");
// next-cycle implication
`define FACL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("facl check failed");
`endif

// ===== rtl/core/facl_pkg.sv =====
package facl_pkg;
  localparam int LINES = 256;
  localparam int LINE_W = $clog2(LINES);
  localparam int TAG_W = 32;
  localparam int AGE_W = 16;
  localparam int PHASE_W = 4;
  localparam logic [PHASE_W-1:0] AGE_PHASES = PHASE_W'(8);
  localparam logic [2:0] BSL_RESET = 3'd1;

  typedef struct packed {
    logic             wr;
    logic [TAG_W-1:0] block;
  } facl_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } facl_state_t;
endpackage

// ===== rtl/core/facl_if.sv =====
interface facl_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] address;
  modport source (output valid, req_type, address, input ready);
  modport sink (input valid, req_type, address, output ready);
endinterface

interface facl_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [7:0]  line_used;
  logic        writeback;
  logic [31:0] victim_block;
  modport source (output valid, hit, line_used, writeback, victim_block, input ready);
  modport sink (input valid, hit, line_used, writeback, victim_block, output ready);
endinterface

// ===== rtl/core/facl_front.sv =====
module facl_front (
  input  logic                 clk,
  input  logic                 rst_n,
  facl_in_if.sink              in_ch,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_wdata,
  output logic                 q_valid,
  input  logic                 q_ready,
  output facl_pkg::facl_item_t q_item
);
  `include "fully_assoc_cache_lru_counters_assert.svh"

  logic [2:0]           bsl_r;
  facl_pkg::facl_item_t ent_r [2];
  logic                 wptr_r, rptr_r;
  logic [1:0]           count_r;
  logic                 push, pop;
  facl_pkg::facl_item_t item_in;

  assign in_ch.ready = (count_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign pop = q_valid && q_ready;
  assign q_valid = (count_r != 2'd0);
  assign q_item = ent_r[rptr_r];

  always_comb begin
    item_in.wr = in_ch.req_type;
    item_in.block = in_ch.address >> bsl_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsl_r <= facl_pkg::BSL_RESET;
    end else if (cfg_we) begin
      bsl_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop) rptr_r <= ~rptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wptr_r] <= item_in;
  end

  `FACL_ASSERT_NOW(a_cnt_range, 1'b1, count_r != 2'd3)
  `FACL_ASSERT_NEXT(a_cnt_push, push && !pop, count_r == $past(count_r) + 2'd1)
  `FACL_ASSERT_NOW(a_pop_nonempty, pop, count_r != 2'd0)
endmodule

// ===== rtl/core/facl_back.sv =====
module facl_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  facl_pkg::facl_item_t q_item,
  facl_out_if.source           out_ch
);
  `include "fully_assoc_cache_lru_counters_assert.svh"

  localparam int LW = facl_pkg::LINE_W;
  localparam int TW = facl_pkg::TAG_W;
  localparam int AW = facl_pkg::AGE_W;
  localparam logic [LW-1:0] LAST = LW'(facl_pkg::LINES - 1);

  facl_pkg::facl_state_t state_r, state_nxt;

  logic [TW-1:0] tag_mem [facl_pkg::LINES];
  logic [AW-1:0] stamp_mem [facl_pkg::LINES];
  logic [TW-1:0] tag_q;
  logic [AW-1:0] stamp_q;

  logic [facl_pkg::LINES-1:0] valid_r, dirty_r;
  logic [AW-1:0]              glob_r;
  logic [facl_pkg::PHASE_W-1:0] phase_r;

  logic [TW-1:0] block_r;
  logic          wr_r;
  logic [LW-1:0] idx_r, cmp_idx_r;
  logic          cmp_v_r;
  logic          found_r;
  logic [LW-1:0] hit_idx_r, best_idx_r;
  logic [AW-1:0] best_age_r;
  logic [TW-1:0] best_tag_r;

  logic          out_valid_r, hit_o_r, wb_o_r;
  logic [7:0]    line_o_r;
  logic [TW-1:0] victim_o_r;

  logic          start, fin;
  logic [AW-1:0] cur_age;
  logic [LW-1:0] line_sel;

  assign q_ready = (state_r == facl_pkg::ST_IDLE) && !out_valid_r;
  assign start = q_valid && q_ready;
  assign fin = (state_r == facl_pkg::ST_FIN);
  // age = time since last touch, wraps like the per-line counters;
  // a line never touched since reset has an implicit stamp of zero
  assign cur_age = valid_r[cmp_idx_r] ? (glob_r - stamp_q) : glob_r;
  assign line_sel = found_r ? hit_idx_r : best_idx_r;

  assign out_ch.valid = out_valid_r;
  assign out_ch.hit = hit_o_r;
  assign out_ch.line_used = line_o_r;
  assign out_ch.writeback = wb_o_r;
  assign out_ch.victim_block = victim_o_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      facl_pkg::ST_IDLE:  if (start) state_nxt = facl_pkg::ST_SCAN;
      facl_pkg::ST_SCAN:  if (idx_r == LAST) state_nxt = facl_pkg::ST_DRAIN;
      facl_pkg::ST_DRAIN: state_nxt = facl_pkg::ST_FIN;
      facl_pkg::ST_FIN:   state_nxt = facl_pkg::ST_IDLE;
      default:            state_nxt = facl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= facl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      stamp_mem[line_sel] <= glob_r;
      if (!found_r) tag_mem[line_sel] <= block_r;
    end
    tag_q <= tag_mem[idx_r];
    stamp_q <= stamp_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
      glob_r <= '0;
      phase_r <= '0;
      cmp_v_r <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r <= '0;
    end else begin
      cmp_v_r <= (state_r == facl_pkg::ST_SCAN);
      if (start) begin
        idx_r <= '0;
        if (phase_r < facl_pkg::AGE_PHASES) begin
          glob_r <= glob_r + AW'(1);
          phase_r <= phase_r + facl_pkg::PHASE_W'(1);
        end else begin
          phase_r <= '0;
        end
      end else if (state_r == facl_pkg::ST_SCAN) begin
        idx_r <= idx_r + LW'(1);
      end
      if (fin) begin
        valid_r[line_sel] <= 1'b1;
        dirty_r[line_sel] <= wr_r || (found_r && dirty_r[line_sel]);
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      block_r <= q_item.block;
      wr_r <= q_item.wr;
      found_r <= 1'b0;
    end
    if (cmp_v_r) begin
      if (valid_r[cmp_idx_r] && tag_q == block_r && !found_r) begin
        found_r <= 1'b1;
        hit_idx_r <= cmp_idx_r;
      end
      // last line wins on equal age
      if (cmp_idx_r == '0 || cur_age >= best_age_r) begin
        best_age_r <= cur_age;
        best_idx_r <= cmp_idx_r;
        best_tag_r <= tag_q;
      end
    end
    if (!cmp_v_r || state_r == facl_pkg::ST_SCAN) cmp_idx_r <= idx_r;
    if (fin) begin
      hit_o_r <= found_r;
      line_o_r <= 8'(line_sel);
      wb_o_r <= !found_r && dirty_r[line_sel];
      victim_o_r <= (!found_r && dirty_r[line_sel]) ? best_tag_r : '0;
    end
  end

  `FACL_ASSERT_NEXT(a_fin_out, fin, out_valid_r)
  `FACL_ASSERT_NOW(a_wb_miss, out_valid_r && wb_o_r, !hit_o_r)
  `FACL_ASSERT_NOW(a_no_start_busy, start, !cmp_v_r)
  `FACL_ASSERT_NEXT(a_drain_fin, state_r == facl_pkg::ST_DRAIN, fin)
endmodule

// ===== rtl/core/fully_assoc_cache_lru_counters.sv =====
// The back end accepts a new word only when idle and its last result word
// has been taken, so words do not overlap; the tag/age scan reads one line
// per cycle from the tag and age memories.
// A two-word queue decouples input acceptance from the scan.
// Reset (rst_n low, synchronous): all lines invalid and clean, ages zero,
// phase zero, block_size_log2 = 1, queue and output empty.
module fully_assoc_cache_lru_counters (
  input  logic       clk,
  input  logic       rst_n,
  facl_in_if.sink    in_ch,
  facl_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata
);
  logic                 q_valid, q_ready;
  facl_pkg::facl_item_t q_item;

  facl_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  facl_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_ch(out_ch)
  );
endmodule
